// ----- design/gda_pkg.sv -----
// gda_pkg: shared types, constants and month length table for the date adder
// no dependencies; imported by gda_ctrl, gda_datapath and the top level

package gda_pkg;

    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int YEAR_W  = 14;
    localparam int DAYS_W  = 16;
    localparam int R400_W  = 9;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 24;

    localparam logic [MONTH_W-1:0] JANUARY  = 4'd1;
    localparam logic [MONTH_W-1:0] FEBRUARY = 4'd2;
    localparam logic [MONTH_W-1:0] DECEMBER = 4'd12;

    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd16383;
    localparam logic [R400_W-1:0] CYCLE400 = 9'd400;
    localparam logic [R400_W-1:0] LAST400  = 9'd399;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic reduce_step;
        logic clamp;
        logic walk_step;
        logic out_load;
    } gda_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic r_ge400;
        logic rem_zero;
    } gda_sts_t;

    // days in month m (1..12), with the leap day in february only
    function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                   input logic is_leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd2:                n = 5'd28;
            4'd4, 4'd6, 4'd9,
            4'd11:               n = 5'd30;
            default:             n = 5'd31;
        endcase
        if (m == FEBRUARY && is_leap) begin
            n = 5'd29;
        end
        return n;
    endfunction

endpackage

// ----- design/gda_datapath.sv -----
// gda_datapath: date registers, year mod 400 reduction and month walk step
// depends on gda_pkg for widths, command/status types and month_len

module gda_datapath (
    input  logic                              aclk,
    input  gda_pkg::gda_cmd_t                 cmd,
    output gda_pkg::gda_sts_t                 sts,
    input  logic [gda_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic [gda_pkg::M_TDATA_W-1:0]     m_tdata
);
    import gda_pkg::*;

    logic [MONTH_W-1:0]   month_reg, month_next;
    logic [DAY_W-1:0]     day_reg, day_next;
    logic [YEAR_W-1:0]    year_reg, year_next;
    logic [DAYS_W-1:0]    rem_reg, rem_next;
    logic [YEAR_W-1:0]    r400_reg, r400_next;
    logic [M_TDATA_W-1:0] out_reg, out_next;

    logic [MONTH_W-1:0] in_month;
    logic [DAY_W-1:0]   in_day;
    logic [R400_W-1:0]  r400;
    logic               is_leap;
    logic [DAY_W-1:0]   len;
    logic [DAY_W-1:0]   left;
    logic [DAY_W:0]     step;

    assign in_month = s_tdata[3:0];
    assign in_day   = s_tdata[8:4];

    // leap: divisible by 4, and by 100 only if by 400
    assign r400    = r400_reg[R400_W-1:0];
    assign is_leap = (year_reg[1:0] == 2'd0) && !(r400 inside {9'd100, 9'd200, 9'd300});
    assign len     = month_len(month_reg, is_leap);
    assign left    = len - day_reg;
    assign step    = {1'b0, left} + 6'd1;

    assign sts.r_ge400  = (r400_reg >= YEAR_W'(CYCLE400));
    assign sts.rem_zero = (rem_reg == '0);

    // next state of the date registers
    always_comb begin
        month_next = month_reg;
        day_next   = day_reg;
        year_next  = year_reg;
        rem_next   = rem_reg;
        r400_next  = r400_reg;
        out_next   = out_reg;
        if (cmd.load) begin
            if (in_month == '0) begin
                month_next = JANUARY;
            end else if (in_month > DECEMBER) begin
                month_next = DECEMBER;
            end else begin
                month_next = in_month;
            end
            day_next  = (in_day == '0) ? DAY_W'(1) : in_day;
            year_next = s_tdata[22:9];
            r400_next = s_tdata[22:9];
            rem_next  = s_tdata[38:23];
        end
        if (cmd.reduce_step) begin
            r400_next = r400_reg - YEAR_W'(CYCLE400);
        end
        if (cmd.clamp && day_reg > len) begin
            day_next = len;
        end
        if (cmd.walk_step) begin
            if (rem_reg > DAYS_W'(left)) begin
                rem_next = rem_reg - DAYS_W'(step);
                day_next = DAY_W'(1);
                if (month_reg == DECEMBER) begin
                    month_next = JANUARY;
                    year_next  = year_reg + YEAR_W'(1);
                    // year wraps to zero, which is a multiple of 400
                    if (year_reg == YEAR_MAX || r400 == LAST400) begin
                        r400_next = '0;
                    end else begin
                        r400_next = r400_reg + YEAR_W'(1);
                    end
                end else begin
                    month_next = month_reg + MONTH_W'(1);
                end
            end else begin
                day_next = day_reg + rem_reg[DAY_W-1:0];
                rem_next = '0;
            end
        end
        if (cmd.out_load) begin
            out_next = {1'b0, year_reg, day_reg, month_reg};
        end
    end

    always_ff @(posedge aclk) begin
        month_reg <= month_next;
        day_reg   <= day_next;
        year_reg  <= year_next;
        rem_reg   <= rem_next;
        r400_reg  <= r400_next;
        out_reg   <= out_next;
    end

    assign m_tdata = out_reg;

endmodule

// ----- design/gda_ctrl.sv -----
// gda_ctrl: sequencer for load, mod 400 reduction, clamp, month walk, output
// depends on gda_pkg for command and status types

module gda_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output gda_pkg::gda_cmd_t cmd,
    input  gda_pkg::gda_sts_t sts
);
    import gda_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_REDUCE = 5'b00010,
        ST_CLAMP  = 5'b00100,
        ST_WALK   = 5'b01000,
        ST_DONE   = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign out_free = !m_tvalid_reg || m_tready;

    // state transitions and commands
    always_comb begin
        state_next      = state_reg;
        cmd             = '0;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_REDUCE;
                end
            end
            ST_REDUCE: begin
                if (sts.r_ge400) begin
                    cmd.reduce_step = 1'b1;
                end else begin
                    state_next = ST_CLAMP;
                end
            end
            ST_CLAMP: begin
                cmd.clamp  = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK: begin
                if (sts.rem_zero) begin
                    state_next = ST_DONE;
                end else begin
                    cmd.walk_step = 1'b1;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    cmd.out_load  = 1'b1;
                    m_tvalid_next = 1'b1;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // the walk only starts once the year residue is below 400
    a_walk_reduced: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_WALK) |-> !sts.r_ge400)
        else $error("walk with unreduced year residue");

    // an accepted word always starts the reduction
    a_accept_reduce: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> (state_reg == ST_REDUCE))
        else $error("accepted word did not start reduction");

    // a finished result waits while the output register is occupied
    a_done_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DONE && m_tvalid && !m_tready) |=> (state_reg == ST_DONE))
        else $error("result overwrote pending output");

endmodule

// ----- design/gregorian_date_add_days_core.sv -----
// Gregorian date advance: adds a day count to a date, one month per walk cycle.
// Steps: repeated subtraction of 400 from the year residue, a day clamp, one walk step per
// month crossed, a final day add, an empty check and the output load.
// One word is processed at a time, from acceptance through the output load.
// A new word is taken while the previous result still waits in the output register.
// Reset: synchronous active-low aresetn clears the sequencer and m_tvalid.

module gregorian_date_add_days_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // month_in[3:0], day_in[8:4], year_in[22:9], days_to_add[38:23], zero[39]
    input  logic [gda_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // month_out[3:0], day_out[8:4], year_out[22:9], zero[23]
    output logic [gda_pkg::M_TDATA_W-1:0] m_tdata
);
    import gda_pkg::*;

    gda_cmd_t cmd;
    gda_sts_t sts;

    // sequencer
    gda_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .sts      (sts)
    );

    // date registers and walk arithmetic
    gda_datapath u_datapath (
        .aclk    (aclk),
        .cmd     (cmd),
        .sts     (sts),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule
